### src/dpd_pkg.sv
package dpd_pkg;

  localparam int unsigned BufferBytes = 64;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned AddrW = $clog2(StoreDepth);
  localparam int unsigned StoreLimitInt =
      (BufferBytes - 1 > StoreDepth - 1) ? StoreDepth - 1 : BufferBytes - 1;
  localparam logic [AddrW-1:0] StoreLimit = AddrW'(StoreLimitInt);

  localparam logic [7:0] ChHeader = 8'h40;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h0A;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [31:0] count_t;

endpackage

### src/dpd_in_if.sv
interface dpd_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  rx_byte;
  logic [31:0] tick_now;
  logic        queue_full;

  modport source(output valid, kind, rx_byte, tick_now, queue_full, input ready);
  modport sink(input valid, kind, rx_byte, tick_now, queue_full, output ready);
endinterface

### src/dpd_out_if.sv
interface dpd_out_if;
  logic        valid;
  logic        ready;
  logic        is_data;
  logic [7:0]  payload_byte;
  logic [5:0]  byte_index;
  logic [5:0]  packet_length;
  logic [31:0] stamp;
  logic        last;
  logic [31:0] errors_seen;

  modport source(output valid, is_data, payload_byte, byte_index, packet_length, stamp,
                 last, errors_seen, input ready);
  modport sink(input valid, is_data, payload_byte, byte_index, packet_length, stamp,
               last, errors_seen, output ready);
endinterface

### src/dpd_ram.sv
module dpd_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/delimited_packet_deframer.sv
// Deframer for packets of the form '@' payload CR LF arriving as serial bytes.
// in_i carries one received byte or one receiver overrun event per beat, with
// the current tick and the state of the downstream packet sink.
// out_o carries the results: a finished packet leaves as a run of data beats,
// one per payload byte, each with its index, the packet length, the tick taken
// at the LF and a last mark on the final byte; every other input beat gives a
// single status beat with last set. Every beat reports the error count.
// A status beat is presented in the cycle after its input beat. For a packet,
// the LF beat starts a read of the payload memory, and each data beat goes
// from the memory's read register into the output register; while out_o does
// not stall, one byte per cycle follows as the memory is read out at one entry
// per cycle. Non-LF bytes are taken one per cycle while out_o does not stall;
// an emitting LF holds input off until the final byte has been loaded.
// The output register lets a new input beat be taken in the cycle its previous
// result is taken. When out_o stalls, results wait in the output register and
// input is held off. Reset returns the framer to hunting for a header and
// clears the error count; the payload memory is not cleared.
module delimited_packet_deframer import dpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpd_in_if.sink    in_i,
  dpd_out_if.source out_o
);

  typedef enum logic [1:0] {
    PhHunt   = 2'd0,
    PhRecv   = 2'd1,
    PhWaitLf = 2'd2
  } phase_e;

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  state_e      state_q;
  phase_e      phase_q, phase_d;
  addr_t       fill_q, fill_d;
  count_t      err_q, err_d;
  addr_t       idx_q, len_q;
  logic [31:0] stamp_q;
  logic        emit;
  logic        store;

  logic        out_valid_q;
  logic        out_is_data_q;
  logic [7:0]  out_byte_q;
  addr_t       out_index_q;
  addr_t       out_length_q;
  logic [31:0] out_stamp_q;
  logic        out_last_q;
  count_t      out_err_q;

  logic        out_free;
  logic        in_fire;
  logic        last_byte;
  logic        ram_we;
  logic        ram_re;
  addr_t       ram_raddr;
  logic [7:0]  ram_rdata;

  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == StIdle) && out_free;
  assign in_fire   = in_i.valid && in_i.ready;
  assign last_byte = (idx_q == len_q - addr_t'(1));

  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    err_d   = err_q;
    emit    = 1'b0;
    store   = 1'b0;
    if (in_i.kind) begin
      err_d = err_q + count_t'(1);
    end else begin
      unique case (phase_q)
        PhHunt: begin
          if (in_i.rx_byte == ChHeader) begin
            phase_d = PhRecv;
            fill_d  = '0;
          end
        end
        PhRecv: begin
          if (in_i.rx_byte == ChCr) begin
            phase_d = PhWaitLf;
          end else if (fill_q < StoreLimit) begin
            store  = 1'b1;
            fill_d = fill_q + addr_t'(1);
          end else begin
            err_d   = err_q + count_t'(1);
            phase_d = PhHunt;
          end
        end
        PhWaitLf: begin
          phase_d = PhHunt;
          if (in_i.rx_byte == ChLf) begin
            if (fill_q == '0 || in_i.queue_full) begin
              err_d = err_q + count_t'(1);
            end else begin
              emit = 1'b1;
            end
          end else begin
            err_d = err_q + count_t'(1);
          end
        end
        default: begin
          phase_d = PhHunt;
        end
      endcase
    end
  end

  assign ram_we    = in_fire && store;
  assign ram_re    = (in_fire && emit) || (state_q == StRead && out_free && !last_byte);
  assign ram_raddr = (state_q == StRead) ? idx_q + addr_t'(1) : '0;

  dpd_ram #(
    .Depth(StoreDepth),
    .Width(8)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q),
    .wdata_i(in_i.rx_byte),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      phase_q       <= PhHunt;
      fill_q        <= '0;
      err_q         <= '0;
      idx_q         <= '0;
      len_q         <= '0;
      stamp_q       <= '0;
      out_valid_q   <= 1'b0;
      out_is_data_q <= 1'b0;
      out_byte_q    <= '0;
      out_index_q   <= '0;
      out_length_q  <= '0;
      out_stamp_q   <= '0;
      out_last_q    <= 1'b0;
      out_err_q     <= '0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        fill_q  <= fill_d;
        err_q   <= err_d;
        if (emit) begin
          state_q     <= StRead;
          idx_q       <= '0;
          len_q       <= fill_q;
          stamp_q     <= in_i.tick_now;
          out_valid_q <= 1'b0;
        end else begin
          out_valid_q   <= 1'b1;
          out_is_data_q <= 1'b0;
          out_byte_q    <= '0;
          out_index_q   <= '0;
          out_length_q  <= '0;
          out_stamp_q   <= '0;
          out_last_q    <= 1'b1;
          out_err_q     <= err_d;
        end
      end else if (state_q == StRead && out_free) begin
        out_valid_q   <= 1'b1;
        out_is_data_q <= 1'b1;
        out_byte_q    <= ram_rdata;
        out_index_q   <= idx_q;
        out_length_q  <= len_q;
        out_stamp_q   <= stamp_q;
        out_last_q    <= last_byte;
        out_err_q     <= err_q;
        if (last_byte) begin
          state_q <= StIdle;
        end else begin
          idx_q <= idx_q + addr_t'(1);
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.is_data       = out_is_data_q;
  assign out_o.payload_byte  = out_byte_q;
  assign out_o.byte_index    = out_index_q;
  assign out_o.packet_length = out_length_q;
  assign out_o.stamp         = out_stamp_q;
  assign out_o.last          = out_last_q;
  assign out_o.errors_seen   = out_err_q;

endmodule
